// ===== src/nmea_sentence_checker_top_defines.svh =====
// ----------------------------------------------------------------------------
// nmea sentence checker assertion macros
// shared concurrent assertion forms for the checker rtl
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define NSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsc_pkg
// types, codes and character tables for the nmea sentence checker
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam int NUM_TYPES = 6;

    // status codes
    localparam logic [1:0] STATUS_ERR     = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
    localparam logic [1:0] STATUS_KNOWN   = 2'd2;

    localparam logic [2:0] TYPE_NONE = 3'd0;

    // header layout
    localparam logic [2:0] PREFIX_LEN = 3'd3;
    localparam logic [2:0] HEADER_LEN = 3'd6;

    // characters and hex decode offsets
    localparam logic [7:0] ASTERISK      = 8'h2A;
    localparam logic [7:0] HEX_ALPHA_MIN = 8'h3A;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;
    localparam logic [7:0] HEX_DIGIT_OFS = 8'h30;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] sentence_type;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } out_word_t;

    // input register contents toward the parser
    typedef struct packed {
        logic     valid;
        in_word_t word;
    } in_hold_t;

    // parser result toward the output register
    typedef struct packed {
        logic      valid;
        out_word_t word;
    } result_t;

    // "$GP"
    function automatic logic [7:0] prefix_char(input logic [1:0] k);
        logic [7:0] c;
        case (k)
            2'd0:    c = 8'h24;
            2'd1:    c = 8'h47;
            default: c = 8'h50;
        endcase
        return c;
    endfunction

    // GGA GSA GSV RMC VTG ZDA, type t in 0..5, character k in 0..2
    function automatic logic [7:0] type_char(input logic [2:0] t, input logic [1:0] k);
        logic [23:0] name;
        case (t)
            3'd0:    name = "GGA";
            3'd1:    name = "GSA";
            3'd2:    name = "GSV";
            3'd3:    name = "RMC";
            3'd4:    name = "VTG";
            default: name = "ZDA";
        endcase
        case (k)
            2'd0:    return name[23:16];
            2'd1:    return name[15:8];
            default: return name[7:0];
        endcase
    endfunction

    // hex decode, low nibble of the difference; lower-case a..f decode like A..F
    function automatic logic [3:0] hex_nibble(input logic [7:0] d);
        logic [7:0] v;
        v = (d >= HEX_ALPHA_MIN) ? (d - HEX_ALPHA_OFS) : (d - HEX_DIGIT_OFS);
        return v[3:0];
    endfunction

endpackage

// ===== src/nsc_in_stage.sv =====
// ----------------------------------------------------------------------------
// nsc_in_stage
// input register for sentence bytes
// ----------------------------------------------------------------------------
module nsc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  nsc_pkg::in_word_t word,
    input  logic              take,
    output nsc_pkg::in_hold_t hold
);

    logic              valid_reg;
    nsc_pkg::in_word_t word_reg;

    // full and not drained this cycle
    assign stall = valid_reg && !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid && !stall)
        begin
            word_reg <= word;
        end
    end

    assign hold.valid = valid_reg;
    assign hold.word  = word_reg;

endmodule

// ===== src/nsc_parser.sv =====
// ----------------------------------------------------------------------------
// nsc_parser
// sentence state, checksum accumulation, header match and result build
// ----------------------------------------------------------------------------
module nsc_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  nsc_pkg::in_word_t word,
    output nsc_pkg::result_t  result
);

    typedef enum logic [2:0] {
        PH_START,
        PH_BODY,
        PH_HI,
        PH_LO,
        PH_DONE
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [2:0] pos_reg, pos_next;
    logic       prefix_ok_reg, prefix_ok_next;
    logic [nsc_pkg::NUM_TYPES-1:0] cand_reg, cand_next;
    logic [3:0] high_nibble_reg, high_nibble_next;

    logic [7:0] b;
    logic [7:0] rx;
    logic [1:0] type_k;
    logic [1:0] prefix_k;
    logic [2:0] first_type;
    logic       in_prefix;
    logic       in_types;

    always_comb
    begin
        b        = word.data_byte;
        in_prefix = pos_reg < nsc_pkg::PREFIX_LEN;
        in_types  = !in_prefix && (pos_reg < nsc_pkg::HEADER_LEN);
        prefix_k  = pos_reg[1:0];
        type_k    = 2'(pos_reg - nsc_pkg::PREFIX_LEN);

        prefix_ok_next = prefix_ok_reg;
        if (in_prefix && (b != nsc_pkg::prefix_char(prefix_k)))
        begin
            prefix_ok_next = 1'b0;
        end

        cand_next = cand_reg;
        for (int t = 0; t < nsc_pkg::NUM_TYPES; t++)
        begin
            if (in_types && (nsc_pkg::type_char(3'(t), type_k) != b))
            begin
                cand_next[t] = 1'b0;
            end
        end

        pos_next = (pos_reg < nsc_pkg::HEADER_LEN) ? (pos_reg + 3'd1) : pos_reg;

        // lowest candidate wins
        first_type = nsc_pkg::TYPE_NONE;
        for (int t = nsc_pkg::NUM_TYPES - 1; t >= 0; t--)
        begin
            if (cand_next[t])
            begin
                first_type = 3'(t + 1);
            end
        end

        rx               = {high_nibble_reg, nsc_pkg::hex_nibble(b)};
        phase_next       = phase_reg;
        xor_next         = xor_reg;
        high_nibble_next = high_nibble_reg;
        result.valid     = 1'b0;
        result.word      = '0;

        case (phase_reg)
            PH_START:
            begin
                phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                if (b == nsc_pkg::ASTERISK)
                begin
                    phase_next = PH_HI;
                end
                else
                begin
                    xor_next = xor_reg ^ b;
                end
            end
            PH_HI:
            begin
                high_nibble_next = nsc_pkg::hex_nibble(b);
                phase_next       = PH_LO;
            end
            PH_LO:
            begin
                result.valid             = fire;
                result.word.computed_sum = xor_reg;
                result.word.received_sum = rx;
                if (rx == xor_reg)
                begin
                    if (prefix_ok_next && (pos_next >= nsc_pkg::HEADER_LEN) &&
                        (cand_next != '0))
                    begin
                        result.word.status        = nsc_pkg::STATUS_KNOWN;
                        result.word.sentence_type = first_type;
                    end
                    else
                    begin
                        result.word.status = nsc_pkg::STATUS_UNKNOWN;
                    end
                end
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (word.last_byte)
        begin
            // sentence cut short before the second digit
            if ((phase_reg != PH_LO) && (phase_reg != PH_DONE))
            begin
                result.valid             = fire;
                result.word.status       = nsc_pkg::STATUS_ERR;
                result.word.sentence_type = nsc_pkg::TYPE_NONE;
                result.word.computed_sum = xor_next;
                result.word.received_sum = '0;
            end
            phase_next       = PH_START;
            xor_next         = '0;
            pos_next         = '0;
            prefix_ok_next   = 1'b1;
            cand_next        = '1;
            high_nibble_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            xor_reg         <= '0;
            pos_reg         <= '0;
            prefix_ok_reg   <= 1'b1;
            cand_reg        <= '1;
            high_nibble_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            xor_reg         <= xor_next;
            pos_reg         <= pos_next;
            prefix_ok_reg   <= prefix_ok_next;
            cand_reg        <= cand_next;
            high_nibble_reg <= high_nibble_next;
        end
    end

endmodule

// ===== src/nsc_out_stage.sv =====
// ----------------------------------------------------------------------------
// nsc_out_stage
// result register toward the downstream side
// ----------------------------------------------------------------------------
module nsc_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  nsc_pkg::result_t   result,
    output logic               space,
    output logic               valid,
    input  logic               stall,
    output nsc_pkg::out_word_t word
);

    logic               valid_reg;
    nsc_pkg::out_word_t word_reg;

    // empty or draining this cycle
    assign space = !valid_reg || !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (space && result.valid)
        begin
            word_reg <= result.word;
        end
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

// ===== src/nmea_sentence_checker_top.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_checker_top
// nmea 0183 checksum check and sentence type decode, one byte per word
// ----------------------------------------------------------------------------
// Takes one sentence byte per input word and sustains one word per clock
// while the result register is free: each byte passes an input register, the
// xor, header compare and hex decode logic, and lands in a result register;
// while the result register is full and stalled, a byte waits in the input
// register. Throughput is set only by the result register: the block
// stalls input only while a finished result waits and the downstream side
// stalls. The first byte after reset or after
// a word with last_byte set starts a sentence; the bytes between it and the
// asterisk are xored, the two following characters are read as hex (lower-case
// a..f decode like upper-case A..F) and one result word comes out after the
// second digit. A sentence that ends before that gives a checksum error
// result; trailing bytes such as CR and LF give nothing.
module nmea_sentence_checker_top (
    input  logic               clk,
    input  logic               rst_n,
    // sentence bytes
    input  logic               byte_valid,
    output logic               byte_stall,
    input  nsc_pkg::in_word_t  byte_word,
    // check results
    output logic               result_valid,
    input  logic               result_stall,
    output nsc_pkg::out_word_t result_word
);

    `include "nmea_sentence_checker_top_defines.svh"

    nsc_pkg::in_hold_t hold;
    nsc_pkg::result_t  result;
    logic              space;
    logic              fire;

    // a held byte is processed when the result register can take its outcome
    assign fire = hold.valid && space;

    nsc_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (byte_valid),
        .stall (byte_stall),
        .word  (byte_word),
        .take  (fire),
        .hold  (hold)
    );

    nsc_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .word   (hold.word),
        .result (result)
    );

    nsc_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .result (result),
        .space  (space),
        .valid  (result_valid),
        .stall  (result_stall),
        .word   (result_word)
    );

    // a passing status means the two sums agree
    `NSC_ASSERT_SAME(a_pass_sums_match,
        result_valid && (result_word.status != nsc_pkg::STATUS_ERR),
        result_word.computed_sum == result_word.received_sum,
        "passing result with differing sums")

    // a type is reported exactly with a known status
    `NSC_ASSERT_SAME(a_type_with_known,
        result_valid,
        (result_word.status == nsc_pkg::STATUS_KNOWN) ==
            (result_word.sentence_type != nsc_pkg::TYPE_NONE),
        "sentence type and status disagree")

    // a result is only produced when the parser consumes a byte
    `NSC_ASSERT_SAME(a_result_needs_fire,
        result.valid,
        fire,
        "result raised without a consumed byte")

    // an accepted byte is held in the input register next cycle
    `NSC_ASSERT_NEXT(a_accept_held,
        byte_valid && !byte_stall,
        hold.valid,
        "accepted byte not held")

endmodule

// ===== tb/nmea_checksum_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_checksum_monitor
// watches both channels of the sentence checker, predicts each result word
// from the accepted sentence bytes and compares it field by field
// ----------------------------------------------------------------------------
module nmea_checksum_monitor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  logic               byte_stall,
    input  nsc_pkg::in_word_t  byte_word,
    input  logic               result_valid,
    input  logic               result_stall,
    input  nsc_pkg::out_word_t result_word,
    output int                 fail_count,
    output int                 pending
);

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_BODY,
        SCAN_HI,
        SCAN_LO,
        SCAN_DONE
    } scan_phase_t;

    localparam logic [23:0]  GP_TEXT    = "$GP";
    localparam logic [143:0] TYPE_TEXT  = "GGAGSAGSVRMCVTGZDA";
    localparam int           REPORT_MAX = 10;

    scan_phase_t        scan;
    logic [7:0]         run_xor;
    logic [2:0]         hdr_pos;
    logic               gp_ok;
    logic [5:0]         name_ok;
    logic [3:0]         hi_digit;
    nsc_pkg::out_word_t sentence_reports[$];
    int                 report_count;

    // hex digit, low four bits of the difference; lower-case a..f decode like A..F
    function automatic logic [3:0] digit_value(input logic [7:0] d);
        logic [7:0] off;
        off = (d >= nsc_pkg::HEX_ALPHA_MIN) ? nsc_pkg::HEX_ALPHA_OFS : nsc_pkg::HEX_DIGIT_OFS;
        return 4'(d - off);
    endfunction

    function void restart_scan();
        scan     = SCAN_START;
        run_xor  = 8'h00;
        hdr_pos  = 3'd0;
        gp_ok    = 1'b1;
        name_ok  = 6'h3F;
        hi_digit = 4'h0;
    endfunction

    task automatic predict_byte(input nsc_pkg::in_word_t w);
        logic [7:0]         b;
        scan_phase_t        was;
        int                 p;
        int                 t;
        logic [7:0]         rx;
        nsc_pkg::out_word_t report;
        bit                 made;
        b    = w.data_byte;
        was  = scan;
        p    = int'(hdr_pos);
        made = 1'b0;
        report = '0;
        // header compare by position, whatever role the byte plays
        if (p < 3) begin
            if (b != GP_TEXT[23 - 8*p -: 8])
                gp_ok = 1'b0;
        end else if (p < 6) begin
            for (t = 0; t < nsc_pkg::NUM_TYPES; t++)
                if (TYPE_TEXT[143 - 8*(3*t + p - 3) -: 8] != b)
                    name_ok[t] = 1'b0;
        end
        if (hdr_pos < nsc_pkg::HEADER_LEN)
            hdr_pos = hdr_pos + 3'd1;
        case (was)
            SCAN_START: scan = SCAN_BODY;
            SCAN_BODY:
            begin
                if (b == nsc_pkg::ASTERISK)
                    scan = SCAN_HI;
                else
                    run_xor = run_xor ^ b;
            end
            SCAN_HI:
            begin
                hi_digit = digit_value(b);
                scan = SCAN_LO;
            end
            SCAN_LO:
            begin
                rx = {hi_digit, digit_value(b)};
                report.status        = nsc_pkg::STATUS_ERR;
                report.sentence_type = nsc_pkg::TYPE_NONE;
                report.computed_sum  = run_xor;
                report.received_sum  = rx;
                if (rx == run_xor) begin
                    report.status = nsc_pkg::STATUS_UNKNOWN;
                    if (gp_ok && hdr_pos >= nsc_pkg::HEADER_LEN && name_ok != 6'h00) begin
                        // lowest matching name wins
                        for (t = nsc_pkg::NUM_TYPES - 1; t >= 0; t--)
                            if (name_ok[t])
                                report.sentence_type = 3'(t + 1);
                        report.status = nsc_pkg::STATUS_KNOWN;
                    end
                end
                made = 1'b1;
                scan = SCAN_DONE;
            end
            default: ;
        endcase
        if (w.last_byte) begin
            // sentence cut before its second digit
            if (was == SCAN_START || was == SCAN_BODY || was == SCAN_HI) begin
                report.status        = nsc_pkg::STATUS_ERR;
                report.sentence_type = nsc_pkg::TYPE_NONE;
                report.computed_sum  = run_xor;
                report.received_sum  = 8'h00;
                made = 1'b1;
            end
            restart_scan();
        end
        if (made)
            sentence_reports.push_back(report);
    endtask

    task automatic check_result(input nsc_pkg::out_word_t got);
        nsc_pkg::out_word_t want;
        bit                 bad;
        if (sentence_reports.size() == 0) begin
            fail_count++;
            if (report_count < REPORT_MAX)
                $display("unexpected result word: status %0d type %0d sum %h rx %h",
                         got.status, got.sentence_type, got.computed_sum, got.received_sum);
            report_count++;
        end else begin
            want = sentence_reports.pop_front();
            bad  = (got.status != want.status)
                || (got.sentence_type != want.sentence_type)
                || (got.computed_sum != want.computed_sum)
                || (got.received_sum != want.received_sum);
            if (bad) begin
                fail_count++;
                if (report_count < REPORT_MAX)
                    $display("result word differs: expected %0d/%0d/%h/%h, got %0d/%0d/%h/%h",
                             want.status, want.sentence_type, want.computed_sum,
                             want.received_sum, got.status, got.sentence_type,
                             got.computed_sum, got.received_sum);
                report_count++;
            end
        end
    endtask

    initial
    begin
        restart_scan();
        fail_count   = 0;
        pending      = 0;
        report_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            restart_scan();
            sentence_reports.delete();
            pending = 0;
        end else begin
            if (result_valid && !result_stall)
                check_result(result_word);
            if (byte_valid && !byte_stall)
                predict_byte(byte_word);
            pending = sentence_reports.size();
        end
    end

endmodule

// ===== tb/nmea_sentence_checker_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker_top_test
// drives sentence bytes into the checker and judges its result words
// ----------------------------------------------------------------------------
// A short directed run covers a known sentence type, a short header with a
// matching sum, early ends in the body and between the digits, lower-case
// digits and a last mark on a trailing byte. Random sentences follow, mostly
// well formed with random header, body and digits, plus noise bytes and cut
// sentences. Both sides idle at random; the receiver once holds off long
// enough to back the block up. The monitor predicts and compares.
module nmea_sentence_checker_top_test;

    localparam int ITEM_TARGET  = 1600;
    localparam int HOLD_START   = 800;
    localparam int HOLD_CYCLES  = 400;
    // longest quiet stretch of a correct run is the hold plus one long gap
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 10;

    logic               clk;
    logic               rst_n;
    logic               byte_valid;
    logic               byte_stall;
    nsc_pkg::in_word_t  byte_word;
    logic               result_valid;
    logic               result_stall;
    nsc_pkg::out_word_t result_word;

    int         fail_count;
    int         pending;
    int         bytes_sent  = 0;
    int         idle_cycles = 0;
    bit         quiet       = 1'b0;
    logic [7:0] line_buf[$];
    string      type_names  = "GGAGSAGSVRMCVTGZDA";
    string      letter_pool = "GSAVRMCTDZ";

    nmea_sentence_checker_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_word    (byte_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    nmea_checksum_monitor sum_mon (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_word    (byte_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog: ends the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("nmea_sentence_checker_top: mismatch");
                $finish;
            end
        end
    end

    // sender gap: mostly none or short, a few long; none in quiet stretches
    function automatic int next_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    // one word on the byte channel; starts and ends at a falling edge
    task automatic send_word(input nsc_pkg::in_word_t w);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_word  <= w;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // send line_buf up to last_at, last mark on that byte; trailing bytes
    // past the digits are not counted as items
    task automatic send_line(input int last_at, input int counted);
        nsc_pkg::in_word_t w;
        int                k;
        for (k = 0; k <= last_at; k++) begin
            w.data_byte = line_buf[k];
            w.last_byte = (k == last_at);
            send_word(w);
            if (k < counted)
                bytes_sent++;
        end
    endtask

    task automatic add_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            line_buf.push_back(s[k]);
    endtask

    // asterisk and two digits for the xor of everything after the first byte
    task automatic add_sum(input bit lower, input bit garbled);
        logic [7:0] x;
        int         k;
        x = 8'h00;
        for (k = 1; k < line_buf.size(); k++)
            x = x ^ line_buf[k];
        line_buf.push_back(nsc_pkg::ASTERISK);
        if (garbled) begin
            line_buf.push_back(8'($urandom_range(0, 255)));
            line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            line_buf.push_back(hex_char(x[7:4], lower));
            line_buf.push_back(hex_char(x[3:0], lower));
        end
    endtask

    task automatic build_random_sentence(output int last_at, output int counted);
        int         r;
        int         n;
        int         k;
        int         name_len;
        int         pick;
        int         body_len;
        logic [7:0] c;
        line_buf.delete();
        r = $urandom_range(0, 99);
        // noise: random bytes, possibly with stray asterisks
        if (r < 10) begin
            n = $urandom_range(1, 16);
            for (k = 0; k < n; k++)
                line_buf.push_back(8'($urandom_range(0, 255)));
            last_at = n - 1;
            counted = n;
            return;
        end
        // mostly '$', then 'G', then mostly 'P', sometimes 'N'
        line_buf.push_back(($urandom_range(0, 19) != 0) ? 8'h24 : 8'($urandom_range(0, 255)));
        line_buf.push_back(8'h47);
        line_buf.push_back(($urandom_range(0, 9) != 0) ? 8'h50 : 8'h4E);
        // type name, sometimes short or made of random letters
        name_len = ($urandom_range(0, 9) != 0) ? 3 : $urandom_range(0, 2);
        pick     = $urandom_range(0, 6);
        for (k = 0; k < name_len; k++) begin
            if (pick == 6)
                c = letter_pool[$urandom_range(0, 9)];
            else
                c = type_names[3*pick + k];
            line_buf.push_back(c);
        end
        if ($urandom_range(0, 3) != 0) begin
            body_len = $urandom_range(1, 20);
            line_buf.push_back(8'h2C);
            for (k = 0; k < body_len; k++) begin
                if ($urandom_range(0, 19) == 0)
                    c = 8'($urandom_range(128, 255));
                else
                    c = 8'($urandom_range(32, 126));
                // keep the first asterisk where the checksum goes
                if (c == nsc_pkg::ASTERISK)
                    c = 8'h2C;
                line_buf.push_back(c);
            end
        end
        r = $urandom_range(0, 99);
        add_sum(r >= 85 && r < 93, r >= 93);
        line_buf.push_back(8'h0D);
        line_buf.push_back(8'h0A);
        n = line_buf.size();
        r = $urandom_range(0, 99);
        if (r < 65) begin
            // full line, mark on LF
            last_at = n - 1;
            counted = n - 2;
        end else if (r < 80) begin
            // mark on the second digit
            last_at = n - 3;
            counted = n - 2;
        end else begin
            // cut before the second digit
            last_at = $urandom_range(0, n - 4);
            counted = last_at + 1;
        end
    endtask

    // receiver: random stall runs, and one long hold counted here
    initial
    begin
        int free_len;
        int hold_len;
        int cycles;
        bit held;
        result_stall = 1'b0;
        cycles = 0;
        held   = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (!held && cycles >= HOLD_START) begin
                // sender keeps offering while results pile up
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            result_stall <= 1'b0;
            free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100)
                                                   : $urandom_range(1, 8);
            repeat (free_len) @(negedge clk);
            cycles += free_len;
            case ($urandom_range(0, 49))
                0:       hold_len = $urandom_range(20, 60);
                1, 2, 3: hold_len = $urandom_range(4, 12);
                default: hold_len = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 3) : 0;
            endcase
            if (hold_len > 0) begin
                result_stall <= 1'b1;
                repeat (hold_len) @(negedge clk);
                cycles += hold_len;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int last_at;
        int counted;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_word  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // known type, upper-case digits, mark on the second digit
        line_buf.delete();
        add_text("$GPGGA");
        add_sum(1'b0, 1'b0);
        send_line(8, 9);
        // all-ones and all-zero bytes, short header with a matching sum
        line_buf.delete();
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);
        add_sum(1'b0, 1'b0);
        send_line(4, 5);
        // sentence ends inside the body
        line_buf.delete();
        add_text("$G");
        send_line(1, 2);
        // lower-case digits with a wrong sum, then a mark on a trailing CR
        line_buf.delete();
        add_text("$*ab");
        line_buf.push_back(8'h0D);
        send_line(4, 4);
        // sentence ends between the two digits
        line_buf.delete();
        add_text("$*1");
        send_line(2, 3);

        while (bytes_sent < ITEM_TARGET) begin
            build_random_sentence(last_at, counted);
            if ($urandom_range(0, 4) == 0)
                quiet = !quiet;
            send_line(last_at, counted);
        end
        byte_valid <= 1'b0;

        // drain, then watch for anything unexpected
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("nmea_sentence_checker_top: match");
        else
            $display("nmea_sentence_checker_top: mismatch");
        $finish;
    end

endmodule
